// File: design/smac_pkg.sv
// Shared types and constants for the moving-average crossover detector.
// No dependencies.
package smac_pkg;
	localparam int unsigned PeriodW = 7;
	localparam int unsigned PriceW = 32;
	localparam int unsigned MAX_WINDOW = 64;
	localparam logic [15:0] CONF_CAP = 16'd62259;

	// configuration register indexes
	localparam logic [0:0] REG_SHORT = 1'b0;
	localparam logic [0:0] REG_LONG  = 1'b1;

	typedef enum logic [1:0] {
		SIG_NONE = 2'd0,
		SIG_BUY  = 2'd1,
		SIG_SELL = 2'd2
	} signal_t;

	// commands from controller to datapath
	typedef struct packed {
		logic store;     // write sample into ring, bump pointer and count
		logic clr_acc;   // clear accumulator and read index
		logic rd;        // issue ring read for current index
		logic rd_prev;   // issue ring read for the sample before the newest
		logic acc;       // add registered read data
		logic take_s;    // latch short sum
		logic take_l;    // latch long sum
		logic take_prev; // latch previous sample
		logic div_start;
		logic [1:0] div_sel; // 0 short, 1 long, 2 change, 3 confidence
		logic finish;    // compute signal, update memory, load output
	} smac_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic rd_done;    // all window reads issued
		logic acc_at_s;   // accumulator holds exactly the short window
		logic acc_at_l;   // accumulator holds exactly the long window
		logic sufficient;
		logic need_conf;  // a crossover occurred
	} smac_stat_t;

	localparam logic [1:0] DSEL_SHORT = 2'd0;
	localparam logic [1:0] DSEL_LONG  = 2'd1;
	localparam logic [1:0] DSEL_CHG   = 2'd2;
	localparam logic [1:0] DSEL_CONF  = 2'd3;
endpackage

// File: design/smac_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on nothing.
module smac_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [63:0] quotient
);
	logic [63:0] q_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], q_q[63]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial;
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = q_q;
endmodule

// File: design/smac_datapath.sv
// Datapath: sample ring, summing accumulator, shared divider and result register.
// Depends on smac_pkg and smac_div.
module smac_datapath import smac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  smac_cmd_t          cmd,
	output smac_stat_t         stat,
	input  logic [PriceW-1:0]  price,
	input  logic [PeriodW-1:0] short_len,
	input  logic [PeriodW-1:0] long_len,
	output logic               status,
	output logic [31:0]        short_avg,
	output logic [31:0]        long_avg,
	output logic [1:0]         signal,
	output logic [15:0]        confidence,
	output logic [31:0]        move_pct
);
	localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
	localparam int unsigned PW = (CW > PeriodW) ? CW : PeriodW;

	logic [31:0] ring [MAX_WINDOW];
	logic [AW-1:0] wptr_q;
	logic [CW-1:0] count_q;
	logic [31:0] cur_q, rd_q, prev_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] nacc_q;
	logic [AW+31:0] acc_q;
	logic [63:0] sum_s_q, sum_l_q;
	logic [31:0] s_q, l_q;
	logic [31:0] last_s_q, last_l_q;
	logic last_v_q;
	logic [63:0] chg_q_q;
	logic chg_neg_q;
	logic [15:0] conf_q;
	logic [1:0] sig_c;
	logic [PW-1:0] sp_eff, lp_eff, n_rd;
	logic s_ok;

	function automatic logic [PW-1:0] eff(input logic [PeriodW-1:0] p);
		logic [PW-1:0] pe;
		pe = PW'(p);
		if (p == '0) return PW'(1);
		if (pe > PW'(MAX_WINDOW)) return PW'(MAX_WINDOW);
		return pe;
	endfunction

	assign sp_eff = eff(short_len);
	assign lp_eff = eff(long_len);
	assign n_rd   = (sp_eff > lp_eff) ? sp_eff : lp_eff;
	assign s_ok   = PW'(count_q) >= sp_eff;

	// divider operand selection
	logic [63:0] dvd;
	logic [31:0] dvs;
	logic [31:0] mag_chg, mag_conf;
	logic        div_busy;
	logic [63:0] quo;

	assign mag_chg  = (cur_q < prev_q) ? prev_q - cur_q : cur_q - prev_q;
	assign mag_conf = (s_q > l_q) ? s_q - l_q : l_q - s_q;

	always_comb begin
		unique case (cmd.div_sel)
			DSEL_SHORT: begin dvd = sum_s_q; dvs = 32'(sp_eff); end
			DSEL_LONG:  begin dvd = sum_l_q; dvs = 32'(lp_eff); end
			DSEL_CHG:   begin dvd = 64'(mag_chg) * 64'd6553600; dvs = prev_q; end
			default:    begin dvd = 64'(mag_conf) * 64'd6553600; dvs = l_q; end
		endcase
	end

	smac_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dvd), .divisor(dvs), .busy(div_busy), .quotient(quo)
	);

	// ring address: idx-th latest, or the sample before the newest
	logic [AW-1:0] raddr;
	assign raddr = cmd.rd_prev ? wptr_q - AW'(2) : wptr_q - AW'(1) - AW'(idx_q);

	always_ff @(posedge clk) begin
		if (cmd.store) ring[wptr_q] <= price;
		if (cmd.rd || cmd.rd_prev) rd_q <= ring[raddr];
	end

	always_comb begin
		sig_c = SIG_NONE;
		if (last_v_q) begin
			if (last_s_q <= last_l_q && s_q > l_q) sig_c = SIG_BUY;
			else if (last_s_q >= last_l_q && s_q < l_q) sig_c = SIG_SELL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			count_q  <= '0;
			last_s_q <= '0;
			last_l_q <= '0;
			last_v_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				wptr_q <= (wptr_q == AW'(MAX_WINDOW - 1)) ? '0 : wptr_q + AW'(1);
				if (count_q != CW'(MAX_WINDOW)) count_q <= count_q + CW'(1);
			end
			if (cmd.finish && stat.sufficient) begin
				last_s_q <= s_q;
				last_l_q <= l_q;
				last_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) cur_q <= price;
		if (cmd.clr_acc) begin
			acc_q  <= '0;
			idx_q  <= '0;
			nacc_q <= '0;
		end else begin
			if (cmd.rd) idx_q <= idx_q + CW'(1);
			if (cmd.acc) begin
				acc_q  <= acc_q + (AW+32)'(rd_q);
				nacc_q <= nacc_q + CW'(1);
			end
		end
		if (cmd.take_s) sum_s_q <= 64'(acc_q);
		if (cmd.take_l) sum_l_q <= 64'(acc_q);
		if (cmd.take_prev) prev_q <= (count_q > CW'(1)) ? rd_q : cur_q;
		// record the sign of the change whenever a division starts
		if (cmd.div_start) chg_neg_q <= cur_q < prev_q;
	end

	// result latches, written when the divider goes idle after each run
	logic busy_d_q;
	logic [1:0] sel_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_d_q <= 1'b0;
		else busy_d_q <= div_busy;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) sel_q <= cmd.div_sel;
		if (busy_d_q && !div_busy) begin
			unique case (sel_q)
				DSEL_SHORT: s_q <= s_ok ? quo[31:0] : '0;
				DSEL_LONG:  l_q <= quo[31:0];
				DSEL_CHG:   chg_q_q <= (prev_q == '0) ? '0 : quo;
				default:    conf_q <= (l_q == '0 || quo > 64'(CONF_CAP)) ? CONF_CAP
				                      : quo[15:0];
			endcase
		end
	end

	logic [31:0] chg_sat;
	always_comb begin
		if (chg_neg_q) chg_sat = (chg_q_q >= 64'h8000_0000) ? 32'h8000_0000
		                         : 32'd0 - chg_q_q[31:0];
		else chg_sat = (chg_q_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : chg_q_q[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status     <= stat.sufficient;
			short_avg  <= stat.sufficient ? s_q : '0;
			long_avg   <= stat.sufficient ? l_q : '0;
			signal     <= stat.sufficient ? sig_c : SIG_NONE;
			confidence <= (stat.sufficient && sig_c != SIG_NONE) ? conf_q : '0;
			move_pct   <= stat.sufficient ? chg_sat : '0;
		end
	end

	// status to the controller; reads stop at the longer window or at the samples held
	always_comb begin
		stat.div_busy   = div_busy | busy_d_q;
		stat.rd_done    = (PW'(idx_q) >= n_rd) || (idx_q >= count_q);
		stat.acc_at_s   = PW'(nacc_q) == sp_eff;
		stat.acc_at_l   = PW'(nacc_q) == lp_eff;
		stat.sufficient = PW'(count_q) >= lp_eff;
		stat.need_conf  = sig_c != SIG_NONE;
	end
endmodule

// File: design/smac_ctrl.sv
// Controller: sequences summation, divisions and result hand-off for one word.
// Depends on smac_pkg.
module smac_ctrl import smac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output smac_cmd_t  cmd,
	input  smac_stat_t stat
);
	typedef enum logic [3:0] {
		IDLE, SUM_RD, SUM_ACC, PREV_RD, PREV_TAKE,
		DIV_S, DIV_L, DIV_C, DIV_F, WAIT_DIV, FIN, OUT
	} state_t;

	state_t state_q, after_q;
	logic   rd_pend_q;
	logic   fin_go;

	assign in_stall = (state_q != IDLE);
	// load the result only once the output register is free
	assign fin_go = (state_q == FIN) && (!out_valid || !out_stall);

	always_comb begin
		cmd = '0;
		cmd.div_sel = DSEL_SHORT;
		unique case (state_q)
			IDLE: begin
				cmd.store   = in_valid;
				cmd.clr_acc = in_valid;
			end
			SUM_RD: begin
				cmd.acc    = rd_pend_q;
				cmd.rd     = !stat.rd_done;
				cmd.take_s = stat.acc_at_s;
				cmd.take_l = stat.acc_at_l;
			end
			SUM_ACC: begin
				cmd.take_s = stat.acc_at_s;
				cmd.take_l = stat.acc_at_l;
			end
			PREV_RD:   cmd.rd_prev = 1'b1;
			PREV_TAKE: cmd.take_prev = 1'b1;
			DIV_S: begin cmd.div_start = 1'b1; cmd.div_sel = DSEL_SHORT; end
			DIV_L: begin cmd.div_start = 1'b1; cmd.div_sel = DSEL_LONG; end
			DIV_C: begin cmd.div_start = 1'b1; cmd.div_sel = DSEL_CHG; end
			DIV_F: begin cmd.div_start = 1'b1; cmd.div_sel = DSEL_CONF; end
			FIN:   cmd.finish = fin_go;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			after_q   <= IDLE;
			rd_pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: if (in_valid) begin
					state_q   <= SUM_RD;
					rd_pend_q <= 1'b0;
				end
				SUM_RD: begin
					rd_pend_q <= !stat.rd_done;
					if (stat.rd_done) state_q <= SUM_ACC;
				end
				SUM_ACC: state_q <= PREV_RD;
				PREV_RD: state_q <= PREV_TAKE;
				PREV_TAKE: state_q <= stat.sufficient ? DIV_S : FIN;
				DIV_S: begin state_q <= WAIT_DIV; after_q <= DIV_L; end
				DIV_L: begin state_q <= WAIT_DIV; after_q <= DIV_C; end
				DIV_C: begin state_q <= WAIT_DIV; after_q <= FIN; end
				DIV_F: begin state_q <= WAIT_DIV; after_q <= OUT; end
				WAIT_DIV: if (!stat.div_busy) begin
					if (after_q == FIN && stat.need_conf) state_q <= DIV_F;
					else if (after_q == OUT) state_q <= FIN;
					else state_q <= after_q;
				end
				FIN: if (fin_go) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
			if (fin_go) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end
endmodule

// File: design/sma_crossover_detector_top.sv
// Moving-average crossover detector, top level.
// With too few samples held the result loads without any division; otherwise the controller
// runs three divisions (short mean, long mean, change) and a fourth for confidence on a
// crossover. One word in flight; the next word is taken the cycle after the result loads,
// and an output stall holds the result back.
// Reset (arst_n low) clears pointer, count and remembered means, periods to 5 and 20.
module sma_crossover_detector_top import smac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] price,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [31:0] short_avg,
	output logic [31:0] long_avg,
	output logic [1:0]  signal,
	output logic [15:0] confidence,
	output logic [31:0] move_pct,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	logic [PeriodW-1:0] short_len_q, long_len_q;
	smac_cmd_t  cmd;
	smac_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_len_q <= 7'd5;
			long_len_q  <= 7'd20;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SHORT: short_len_q <= cfg_data;
				REG_LONG:  long_len_q  <= cfg_data;
			endcase
		end
	end

	smac_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
	);

	smac_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .price(price),
		.short_len(short_len_q), .long_len(long_len_q),
		.status(status), .short_avg(short_avg), .long_avg(long_avg),
		.signal(signal), .confidence(confidence), .move_pct(move_pct)
	);
endmodule

// File: test/tb_sma_crossover_detector_top.sv
// Testbench for the moving-average crossover detector top level.
// Drives price words and register writes, predicts each result and checks it field by field.
// Depends on smac_pkg and sma_crossover_detector_top.
module tb_sma_crossover_detector_top;
	import smac_pkg::*;

	localparam int RingDepth = 64;

	typedef struct {
		logic        status;
		logic [31:0] short_avg;
		logic [31:0] long_avg;
		signal_t     sig;
		logic [15:0] confidence;
		logic [31:0] move_pct;
	} crossover_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [31:0] price;
	logic status;
	logic [31:0] short_avg, long_avg, move_pct;
	logic [1:0] signal;
	logic [15:0] confidence;
	logic cfg_valid, cfg_ready;
	logic [0:0] cfg_index;
	logic [6:0] cfg_data;

	sma_crossover_detector_top dut (.*);

	// predictor state
	logic [31:0] ring [RingDepth];
	logic [5:0]  wr_ptr;
	logic [6:0]  held;
	logic [31:0] prev_short, prev_long;
	logic        prev_ok;
	logic [6:0]  short_reg, long_reg;

	logic [31:0] price_queue [$];
	crossover_t  expected_results [$];
	int errors;
	bit calm;
	int hold_reqs, hold_served, hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("[sma_crossover_detector_top] ERROR");
		$finish;
	end

	function automatic logic [6:0] eff_period(logic [6:0] p);
		if (p == 0) return 7'd1;
		if (p > RingDepth) return 7'(RingDepth);
		return p;
	endfunction

	function automatic logic [31:0] window_mean(logic [6:0] p);
		logic [63:0] sum;
		sum = 0;
		if (held < p) return 32'd0;
		for (int i = 0; i < p; i++)
			sum += ring[6'(wr_ptr - 1 - i)];
		return 32'(sum / p);
	endfunction

	function automatic logic [31:0] pct_change(logic [31:0] cur, logic [31:0] prv);
		logic [63:0] mag, q;
		if (prv == 0) return 32'd0;
		mag = (cur < prv) ? 64'(prv - cur) : 64'(cur - prv);
		q = (mag * 64'd100 * 64'd65536) / prv;
		if (cur < prv) begin
			if (q >= 64'h8000_0000) return 32'h8000_0000;
			return 32'(0 - q);
		end
		if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
		return 32'(q);
	endfunction

	function automatic logic [15:0] conf_of(logic [31:0] s, logic [31:0] l);
		logic [63:0] d, q;
		if (l == 0) return CONF_CAP;
		d = (s > l) ? 64'(s - l) : 64'(l - s);
		q = (d * 64'd100 * 64'd65536) / l;
		return (q > CONF_CAP) ? CONF_CAP : 16'(q);
	endfunction

	task automatic crossover_predict(logic [31:0] p);
		crossover_t r;
		logic [6:0] sp, lp;
		logic [31:0] prv;
		sp = eff_period(short_reg);
		lp = eff_period(long_reg);
		ring[wr_ptr] = p;
		wr_ptr = wr_ptr + 1;
		if (held < RingDepth) held = held + 1;
		r = '{1'b0, 32'd0, 32'd0, SIG_NONE, 16'd0, 32'd0};
		if (held >= lp) begin
			r.status = 1'b1;
			r.short_avg = window_mean(sp);
			r.long_avg = window_mean(lp);
			prv = (held > 1) ? ring[6'(wr_ptr - 2)] : p;
			r.move_pct = pct_change(p, prv);
			if (prev_ok) begin
				if (prev_short <= prev_long && r.short_avg > r.long_avg) r.sig = SIG_BUY;
				else if (prev_short >= prev_long && r.short_avg < r.long_avg) r.sig = SIG_SELL;
			end
			if (r.sig != SIG_NONE) r.confidence = conf_of(r.short_avg, r.long_avg);
			prev_short = r.short_avg;
			prev_long = r.long_avg;
			prev_ok = 1'b1;
		end
		expected_results = {expected_results, r};
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) crossover_predict(price);
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && in_stall) begin
			in_valid <= 1'b1;
		end else if (price_queue.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
			in_valid <= 1'b1;
			price <= price_queue.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		crossover_t e;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (short_avg !== e.short_avg) report_mismatch("short_avg", short_avg, e.short_avg);
				if (long_avg !== e.long_avg) report_mismatch("long_avg", long_avg, e.long_avg);
				if (signal !== e.sig) report_mismatch("signal", signal, e.sig);
				if (confidence !== e.confidence)
					report_mismatch("confidence", confidence, e.confidence);
				if (move_pct !== e.move_pct)
					report_mismatch("move_pct", move_pct, e.move_pct);
			end
		end
		if (hold_reqs != hold_served) begin
			hold_served = hold_reqs;
			hold_left = 800;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && $urandom_range(99) < 6;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [6:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SHORT) short_reg = val;
		else long_reg = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		while (price_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// mostly a random walk so the means cross often; some wild words and zeros
	task automatic queue_random(int n);
		logic [31:0] walk;
		walk = $urandom_range(32'h0010_0000, 32'h0000_1000);
		repeat (n) begin
			case ($urandom_range(19))
				0: price_queue = {price_queue, 32'($urandom())};
				1: price_queue = {price_queue, 32'd0};
				2: price_queue = {price_queue, 32'(32'hFFFF_FFFF - $urandom_range(255))};
				default: begin
					if ($urandom_range(1)) walk = walk + $urandom_range(4095);
					else if (walk > 4096) walk = walk - $urandom_range(4095);
					price_queue = {price_queue, walk};
				end
			endcase
		end
	endtask

	initial begin
		logic [6:0] picks [8];
		picks = '{7'd0, 7'd1, 7'd2, 7'd5, 7'd20, 7'd63, 7'd64, 7'd127};
		arst_n = 1'b0;
		in_valid = 1'b0;
		price = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SHORT;
		cfg_data = '0;
		errors = 0;
		calm = 1'b0;
		hold_reqs = 0;
		hold_served = 0;
		hold_left = 0;
		wr_ptr = '0;
		held = '0;
		prev_short = '0;
		prev_long = '0;
		prev_ok = 1'b0;
		short_reg = 7'd5;
		long_reg = 7'd20;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// single window: one sample held, falls to zero, zero previous, saturation
		write_reg(REG_SHORT, 7'd0);
		write_reg(REG_LONG, 7'd1);
		price_queue = '{32'd5, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd256};
		drain();

		// crossovers on a zero long mean, then a buy and a sell
		write_reg(REG_SHORT, 7'd1);
		write_reg(REG_LONG, 7'd2);
		price_queue = '{32'd0, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd7};
		drain();

		// short period above the ring depth, short window longer than held samples
		write_reg(REG_SHORT, 7'd127);
		write_reg(REG_LONG, 7'd3);
		price_queue = '{32'd100, 32'd200, 32'd300, 32'd400};
		drain();

		for (int ph = 0; ph < 11; ph++) begin
			write_reg(REG_SHORT, picks[$urandom_range(7)]);
			write_reg(REG_LONG, picks[$urandom_range(7)]);
			if (ph == 3) write_reg(REG_SHORT, 7'd64);
			calm = (ph == 5);
			if (ph == 7) hold_reqs++;
			queue_random(100);
			drain();
		end
		calm = 1'b0;
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("[sma_crossover_detector_top] OK");
		else
			$display("[sma_crossover_detector_top] ERROR");
		$finish;
	end
endmodule
